// ===== rtl/pcms16_pkg.sv =====
`timescale 1ns / 1ps

package pcms16_pkg;

    localparam logic [2:0] FMT_U8  = 3'd0;
    localparam logic [2:0] FMT_S16 = 3'd1;
    localparam logic [2:0] FMT_S24 = 3'd2;
    localparam logic [2:0] FMT_S32 = 3'd3;
    localparam logic [2:0] FMT_F32 = 3'd4;
    localparam logic [2:0] FMT_F64 = 3'd5;

    localparam logic [2:0] FORMAT_RESET = FMT_S16;

    localparam logic signed [15:0] PCM_MAX = 16'sh7FFF;
    localparam logic signed [15:0] PCM_MIN = 16'sh8000;

    typedef struct packed {
        logic [63:0] sample_word;
        logic        last_in;
    } sample_in_t;

    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic               last_out;
    } result_t;

endpackage

// ===== rtl/pcm_sample_to_s16_converter.sv =====
`timescale 1ns / 1ps

// PCM sample to signed 16-bit converter.
// A request is presented on sample_in with start high; it is taken at any
// rising edge where start is high and busy is low. Busy is always low, so a
// new request may be issued every clock cycle.
// The source format comes from the configuration channel (cfg_valid,
// cfg_ready, cfg_data); cfg_ready is always high. Change it only while no
// request is in flight.
// Each request gives one result on result, marked by done for exactly one
// cycle. The request passes one input register and one result register,
// with the conversion logic between them. Throughput is one request per
// cycle.
// The receiver cannot stall; a result is valid only in its done cycle.
// Reset clears the pipeline valids and sets the format to signed 16-bit.
// Unknown format codes give a zero sample; the last flag always passes.
module pcm_sample_to_s16_converter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  pcms16_pkg::sample_in_t sample_in,
    output logic                   done,
    output pcms16_pkg::result_t    result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_data
);
    import pcms16_pkg::*;

    logic [2:0]         format_reg;
    logic               in_valid_reg;
    sample_in_t         in_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    logic signed [15:0] f32_value;
    logic signed [15:0] f64_value;
    result_t            out_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = out_valid_reg;
    assign result    = out_reg;

    pcms16_float_conv #(.EW(8), .MW(23)) u_f32 (
        .bits  (in_reg.sample_word[31:0]),
        .value (f32_value)
    );

    pcms16_float_conv #(.EW(11), .MW(52)) u_f64 (
        .bits  (in_reg.sample_word),
        .value (f64_value)
    );

    always_comb
    begin
        out_next.last_out = in_reg.last_in;
        unique case (format_reg)
            FMT_U8:  out_next.pcm_sample = {in_reg.sample_word[7] ^ 1'b1,
                                            in_reg.sample_word[6:0], 8'd0};
            FMT_S16: out_next.pcm_sample = in_reg.sample_word[15:0];
            FMT_S24: out_next.pcm_sample = in_reg.sample_word[23:8];
            FMT_S32: out_next.pcm_sample = in_reg.sample_word[31:16];
            FMT_F32: out_next.pcm_sample = f32_value;
            FMT_F64: out_next.pcm_sample = f64_value;
            default: out_next.pcm_sample = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg    <= FORMAT_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                format_reg <= cfg_data;
            in_valid_reg  <= start && !busy;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            in_reg <= sample_in;
        if (in_valid_reg)
            out_reg <= out_next;
    end

endmodule

// ===== rtl/pcms16_float_conv.sv =====
`timescale 1ns / 1ps

module pcms16_float_conv #(
    parameter int EW = 8,
    parameter int MW = 23
) (
    input  logic [EW+MW:0]     bits,
    output logic signed [15:0] value
);
    import pcms16_pkg::*;

    localparam int PW   = MW + 16;
    localparam int BIAS = (1 << (EW - 1)) - 1;
    localparam int SW   = EW + 2;

    logic                 sign;
    logic [EW-1:0]        expo;
    logic [MW-1:0]        frac;
    logic [MW:0]          mant;
    logic [PW-1:0]        prod;
    logic                 top;
    logic [MW:0]          kept;
    logic                 lsb;
    logic                 rb;
    logic                 st;
    logic [MW+1:0]        rnd;
    logic signed [SW-1:0] shamt;
    logic [MW+1:0]        mag;
    logic                 sat;
    logic                 zero;

    assign sign = bits[EW+MW];
    assign expo = bits[EW+MW-1:MW];
    assign frac = bits[MW-1:0];
    assign mant = {1'b1, frac};

    // Multiplying by 32767 is a shift by 15 less the operand.
    assign prod = {mant, 15'd0} - {15'd0, mant};
    assign top  = prod[PW-1];

    always_comb
    begin
        if (top)
        begin
            kept = prod[PW-1:15];
            lsb  = prod[15];
            rb   = prod[14];
            st   = |prod[13:0];
        end
        else
        begin
            kept = prod[PW-2:14];
            lsb  = prod[14];
            rb   = prod[13];
            st   = |prod[12:0];
        end
    end

    assign rnd   = {1'b0, kept} + (MW + 2)'(rb & (st | lsb));
    assign shamt = SW'(BIAS + MW) - (top ? SW'(15) : SW'(14)) - SW'({2'b00, expo});

    always_comb
    begin
        sat  = 1'b0;
        zero = 1'b0;
        mag  = rnd >> $unsigned(shamt);
        if (&expo)
        begin
            zero = (frac != '0);
            sat  = (frac == '0);
        end
        else if (expo == '0)
        begin
            zero = 1'b1;
        end
        else if (shamt <= 0)
        begin
            sat = 1'b1;
        end
        else if (shamt >= SW'(MW + 2))
        begin
            zero = 1'b1;
        end
        else if (mag > (MW + 2)'(32767))
        begin
            sat = 1'b1;
        end
    end

    always_comb
    begin
        if (zero)
            value = '0;
        else if (sat)
            value = sign ? PCM_MIN : PCM_MAX;
        else if (sign)
            value = 16'(16'd0 - mag[15:0]);
        else
            value = mag[15:0];
    end

endmodule
